[design/wxmr_pkg.sv]
// package for the wormhole xy mesh router: port codes, commands, widths
// no dependencies
`default_nettype none
package wxmr_pkg;
	localparam int BUFFER_DEPTH_DEF = 8;
	localparam int PORT_COUNT = 5;
	localparam int FLIT_BITS = 32;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 4;
	localparam logic [2:0] PORT_EAST = 3'd0;
	localparam logic [2:0] PORT_WEST = 3'd1;
	localparam logic [2:0] PORT_NORTH = 3'd2;
	localparam logic [2:0] PORT_SOUTH = 3'd3;
	localparam logic [2:0] PORT_LOCAL = 3'd4;
	localparam logic [2:0] ROUTE_NONE = 3'd5;
	localparam logic [1:0] CMD_FLIT = 2'd0;
	localparam logic [1:0] CMD_STATUS = 2'd1;
	localparam logic [1:0] CMD_LOCAL = 2'd2;
	localparam logic [1:0] CMD_POLL = 2'd3;
	localparam logic CFG_NODE_X = 1'b0;
	localparam logic CFG_NODE_Y = 1'b1;
	localparam logic [1:0] PHASE_HEADER = 2'd0;
	localparam logic [1:0] PHASE_SIZE = 2'd1;
	localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] in_port;
		logic [31:0] flit_in;
		logic neighbour_go;
		logic local_ack;
	} item_t;

	typedef struct packed {
		logic result_kind;
		logic [2:0] out_port;
		logic [31:0] flit_out;
		logic [2:0] status_port;
		logic status_stall;
		logic last;
	} result_t;
endpackage
`default_nettype wire

[design/wxmr_if.sv]
// valid/ready channel interface carrying one payload struct
// depends on nothing but the payload type given as a parameter
`default_nettype none
interface wxmr_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/wxmr_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module wxmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

[design/wormhole_xy_mesh_router_top.sv]
// wormhole xy mesh router: top level with sequencer, per-port ring pointers, routing
// depends on wxmr_pkg, wxmr_if, wxmr_ram
//
// Usage: items enter on in_ch (cmd, in_port, flit_in, neighbour_go, local_ack).
// Each item produces zero or more results on out_ch; the final one carries last.
// Node coordinates are written through cfg_we/cfg_index/cfg_data while idle.
// The block handles one item at a time: in_ch.ready is low from the accepted
// transfer until the last result has been transferred and the scan is done.
// Sequence: the item is applied first, then each of the five ports is scanned
// through flit store read, route and drain check, and each forwarded flit
// repeats those steps since the new head is read again. A result is held in a
// pending register until the next result is made or the scan is done, so the
// final one can carry last. The ports are scanned in turn, since the flit
// store has a single read port and the route/compare unit is shared.
// A result waits in the output register while out_ch.ready is low; the
// sequencer holds at the next result until that transfer.
// Reset clears pointers, bindings and packet phases, sets all neighbours to go,
// local to not ready and both coordinates to 15. The flit store needs no clearing.
`default_nettype none
module wormhole_xy_mesh_router_top #(
	parameter int BUFFER_DEPTH = wxmr_pkg::BUFFER_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	wxmr_if.sink in_ch,
	wxmr_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [wxmr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [wxmr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int NP = wxmr_pkg::PORT_COUNT;
	localparam int MD = NP * BUFFER_DEPTH;
	localparam int AW = $clog2(MD);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_APPLY = 6'b000010,
		ST_ROUTE = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_READ = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	wxmr_pkg::item_t item_q;
	logic [PW-1:0] wp_q [NP];
	logic [PW-1:0] rp_q [NP];
	logic [7:0] rem_q [NP];
	logic [1:0] phase_q [NP];
	logic [2:0] bind_q [NP];
	logic [NP-1:0] ngo_q;
	logic local_rdy_q;
	logic [3:0] node_x_q, node_y_q;
	logic [2:0] port_q;
	logic peek_q;
	logic out_valid_q;
	wxmr_pkg::result_t out_q;
	logic pend_valid_q;
	wxmr_pkg::result_t pend_q;

	// ram ports
	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [31:0] ram_rd;

	wxmr_ram #(.WIDTH(wxmr_pkg::FLIT_BITS), .DEPTH(MD)) u_store (
		.clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(item_q.flit_in),
		.rd_addr(ram_ra), .rd_data(ram_rd)
	);

	function automatic logic [PW-1:0] occ(input logic [PW-1:0] w, input logic [PW-1:0] r);
		logic [PW:0] d;
		d = {1'b0, w} + (PW+1)'(BUFFER_DEPTH) - {1'b0, r};
		if (d >= (PW+1)'(BUFFER_DEPTH)) d = d - (PW+1)'(BUFFER_DEPTH);
		return d[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] v);
		logic [PW:0] s;
		s = {1'b0, v} + 1'b1;
		if (s == (PW+1)'(BUFFER_DEPTH)) s = '0;
		return s[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr(input logic [2:0] p, input logic [PW-1:0] i);
		return AW'(p * BUFFER_DEPTH) + AW'(i);
	endfunction

	// scan port view
	logic [2:0] pidx;
	logic [PW-1:0] cur_occ;
	logic cur_full_after_pop;
	logic [2:0] route_to;
	logic taken;
	logic [3:0] dx, dy;
	assign pidx = port_q;
	assign cur_occ = occ(wp_q[pidx], rp_q[pidx]);
	assign dx = ram_rd[31:28];
	assign dy = ram_rd[27:24];

	// xy route of the header at the head of the current port
	always_comb begin
		if (dx == node_x_q && dy == node_y_q) route_to = wxmr_pkg::PORT_LOCAL;
		else if (node_x_q < dx) route_to = wxmr_pkg::PORT_EAST;
		else if (node_x_q > dx) route_to = wxmr_pkg::PORT_WEST;
		else if (node_y_q < dy) route_to = wxmr_pkg::PORT_NORTH;
		else route_to = wxmr_pkg::PORT_SOUTH;
		taken = 1'b0;
		for (int q = 0; q < NP; q++) if (bind_q[q] == route_to) taken = 1'b1;
	end

	// the drain step condition for the current port
	logic can_pop;
	always_comb begin
		can_pop = 1'b0;
		if (cur_occ != '0) begin
			if (bind_q[pidx] == wxmr_pkg::PORT_LOCAL) can_pop = local_rdy_q && !peek_q;
			else if (bind_q[pidx] < wxmr_pkg::PORT_LOCAL) can_pop = ngo_q[bind_q[pidx]];
		end
	end

	assign ram_we = (state_q == ST_APPLY) && item_q.cmd == wxmr_pkg::CMD_FLIT
		&& item_q.in_port < 3'(NP)
		&& occ(wp_q[item_q.in_port], rp_q[item_q.in_port]) != PW'(BUFFER_DEPTH - 1);
	assign ram_wa = addr(item_q.in_port, wp_q[item_q.in_port]);
	assign ram_ra = addr(pidx, rp_q[pidx]);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	logic out_free;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cur_full_after_pop = occ(wp_q[pidx], inc(rp_q[pidx])) == PW'(BUFFER_DEPTH - 1);

	// result made this cycle; the pending register is always empty at apply
	logic gen;
	logic gen_ok;
	logic flush;
	wxmr_pkg::result_t gen_r;
	wxmr_pkg::result_t flush_r;
	assign gen_ok = !pend_valid_q || out_free;
	always_comb begin
		gen = 1'b0;
		gen_r = '0;
		if (state_q == ST_APPLY && item_q.cmd == wxmr_pkg::CMD_FLIT
				&& item_q.in_port < 3'(NP)) begin
			gen = 1'b1;
			gen_r.status_port = item_q.in_port;
			gen_r.status_stall = occ(inc(wp_q[item_q.in_port]), rp_q[item_q.in_port])
				== PW'(BUFFER_DEPTH - 1) || !ram_we;
		end else if (state_q == ST_DRAIN && can_pop && gen_ok) begin
			gen = 1'b1;
			gen_r.result_kind = 1'b1;
			gen_r.out_port = bind_q[pidx];
			gen_r.flit_out = ram_rd;
			gen_r.status_port = pidx;
			gen_r.status_stall = cur_full_after_pop;
		end
	end

	// pending result moves out when the next one comes or the scan is done
	assign flush = pend_valid_q && out_free && (gen || state_q == ST_DONE);
	always_comb begin
		flush_r = pend_q;
		flush_r.last = (state_q == ST_DONE);
	end

	// output and pending valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (flush) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (gen) pend_valid_q <= 1'b1;
			else if (flush) pend_valid_q <= 1'b0;
		end
	end

	// item, pending and output data
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
		if (gen) pend_q <= gen_r;
		if (flush) out_q <= flush_r;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int p = 0; p < NP; p++) begin
				wp_q[p] <= '0;
				rp_q[p] <= '0;
				rem_q[p] <= '0;
				phase_q[p] <= wxmr_pkg::PHASE_HEADER;
				bind_q[p] <= wxmr_pkg::ROUTE_NONE;
			end
			ngo_q <= '1;
			local_rdy_q <= 1'b0;
			node_x_q <= 4'hF;
			node_y_q <= 4'hF;
			port_q <= '0;
			peek_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wxmr_pkg::CFG_NODE_X: node_x_q <= cfg_data;
					wxmr_pkg::CFG_NODE_Y: node_y_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					// apply the command, then begin the scan at east
					port_q <= '0;
					peek_q <= 1'b0;
					if (item_q.cmd == wxmr_pkg::CMD_FLIT && item_q.in_port < 3'(NP)) begin
						if (ram_we) wp_q[item_q.in_port] <= inc(wp_q[item_q.in_port]);
					end else begin
						if (item_q.cmd == wxmr_pkg::CMD_STATUS && item_q.in_port < 3'(NP))
							ngo_q[item_q.in_port] <= item_q.neighbour_go;
						if (item_q.cmd == wxmr_pkg::CMD_LOCAL) local_rdy_q <= item_q.local_ack;
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					// flit store read of the head of the current port
					state_q <= ST_ROUTE;
				end
				ST_ROUTE: begin
					// bind a free port with a waiting header, first visit only
					if (bind_q[pidx] == wxmr_pkg::ROUTE_NONE && cur_occ != '0 && !taken
							&& !peek_q)
						bind_q[pidx] <= route_to;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (can_pop) begin
						if (gen_ok) begin
							rp_q[pidx] <= inc(rp_q[pidx]);
							peek_q <= 1'b1;
							if (bind_q[pidx] == wxmr_pkg::PORT_LOCAL) local_rdy_q <= 1'b0;
							unique case (phase_q[pidx])
								wxmr_pkg::PHASE_HEADER: phase_q[pidx] <= wxmr_pkg::PHASE_SIZE;
								wxmr_pkg::PHASE_SIZE: begin
									if (ram_rd[31:24] == 8'd0) begin
										bind_q[pidx] <= wxmr_pkg::ROUTE_NONE;
										phase_q[pidx] <= wxmr_pkg::PHASE_HEADER;
									end else begin
										rem_q[pidx] <= ram_rd[31:24];
										phase_q[pidx] <= wxmr_pkg::PHASE_PAYLOAD;
									end
								end
								default: begin
									if (rem_q[pidx] == 8'd1) begin
										bind_q[pidx] <= wxmr_pkg::ROUTE_NONE;
										phase_q[pidx] <= wxmr_pkg::PHASE_HEADER;
										rem_q[pidx] <= '0;
									end else begin
										rem_q[pidx] <= rem_q[pidx] - 8'd1;
									end
								end
							endcase
							// pointer moved: reread the head
							state_q <= ST_READ;
						end
					end else begin
						peek_q <= 1'b0;
						if (pidx == 3'(NP - 1)) state_q <= ST_DONE;
						else begin
							port_q <= pidx + 3'd1;
							state_q <= ST_READ;
						end
					end
				end
				ST_DONE: begin
					// final result is marked as it moves out; leave once output drains
					if (!pend_valid_q && (!out_valid_q || out_ch.ready)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/wxmr_checker.sv]
// port-level checker for the router, bound to the top level
// depends on wxmr_pkg and the top level's ports
`default_nettype none
module wxmr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire wxmr_pkg::result_t out_data
);
	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	// a status-only result carries no flit
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_kind |-> out_data.flit_out == '0
		&& out_data.out_port == '0) else $error("status result with flit");
	// a stalled result other than the last holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !out_data.last |=> out_valid)
		else $error("result dropped");
	// status port always names a real port
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status_port < 3'(wxmr_pkg::PORT_COUNT))
		else $error("bad status port");
endmodule

bind wormhole_xy_mesh_router_top wxmr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

[sim/wormhole_xy_mesh_router_top_tb.sv]
// self-checking testbench for the wormhole xy mesh router top level
// depends on wxmr_pkg, wxmr_if and the router rtl; predicts every result from its own router model
`default_nettype none
module wormhole_xy_mesh_router_top_tb;
	import wxmr_pkg::*;

	localparam int DEPTH = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	wxmr_if #(.payload_t(item_t)) in_ch ();
	wxmr_if #(.payload_t(result_t)) out_ch ();

	wormhole_xy_mesh_router_top #(.BUFFER_DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// router model state
	logic [31:0] buf_flits [PORT_COUNT][DEPTH];
	int wr_ptr [PORT_COUNT];
	int rd_ptr [PORT_COUNT];
	int payload_left [PORT_COUNT];
	logic [1:0] phase [PORT_COUNT];
	logic [2:0] bound_to [PORT_COUNT];
	logic nb_go [PORT_COUNT];
	logic local_rdy;
	logic [3:0] my_x;
	logic [3:0] my_y;

	item_t item_q [$];
	result_t forwarded_q [$];
	int err_cnt;
	bit no_gaps;
	int send_gap;
	int recv_stall;
	int quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int fill_level(int p);
		return (wr_ptr[p] + DEPTH - rd_ptr[p]) % DEPTH;
	endfunction

	function automatic void post_result(logic kind, logic [2:0] op, logic [31:0] f, int p);
		result_t r;
		r.result_kind = kind;
		r.out_port = op;
		r.flit_out = f;
		r.status_port = 3'(p);
		r.status_stall = (fill_level(p) == DEPTH - 1);
		r.last = 1'b0;
		forwarded_q.push_back(r);
	endfunction

	function automatic void free_route(int p);
		bound_to[p] = ROUTE_NONE;
		phase[p] = PHASE_HEADER;
		payload_left[p] = 0;
	endfunction

	function automatic void model_reset();
		for (int p = 0; p < PORT_COUNT; p++) begin
			wr_ptr[p] = 0;
			rd_ptr[p] = 0;
			free_route(p);
			nb_go[p] = 1'b1;
		end
		local_rdy = 1'b0;
		my_x = 4'hF;
		my_y = 4'hF;
	endfunction

	function automatic void forward_flit(int p);
		logic [2:0] op;
		logic [31:0] v;
		op = bound_to[p];
		v = buf_flits[p][rd_ptr[p]];
		rd_ptr[p] = (rd_ptr[p] + 1) % DEPTH;
		if (phase[p] == PHASE_HEADER) begin
			phase[p] = PHASE_SIZE;
		end else if (phase[p] == PHASE_SIZE) begin
			if (v[31:24] == 8'd0) begin
				free_route(p);
			end else begin
				payload_left[p] = int'(v[31:24]);
				phase[p] = PHASE_PAYLOAD;
			end
		end else begin
			payload_left[p] = (payload_left[p] - 1) & 8'hFF;
			if (payload_left[p] == 0)
				free_route(p);
		end
		post_result(1'b1, op, v, p);
	endfunction

	function automatic logic [2:0] xy_target(logic [31:0] hdr);
		logic [3:0] dx;
		logic [3:0] dy;
		dx = hdr[31:28];
		dy = hdr[27:24];
		if (dx == my_x && dy == my_y) return PORT_LOCAL;
		if (my_x < dx) return PORT_EAST;
		if (my_x > dx) return PORT_WEST;
		if (my_y < dy) return PORT_NORTH;
		return PORT_SOUTH;
	endfunction

	// apply one item to the model and queue the results it causes
	function automatic void route_item(item_t it);
		int first;
		logic [2:0] to;
		bit taken;
		first = forwarded_q.size();
		if (it.cmd == CMD_FLIT) begin
			if (it.in_port < PORT_COUNT) begin
				if (fill_level(it.in_port) != DEPTH - 1) begin
					buf_flits[it.in_port][wr_ptr[it.in_port]] = it.flit_in;
					wr_ptr[it.in_port] = (wr_ptr[it.in_port] + 1) % DEPTH;
				end
				post_result(1'b0, 3'd0, 32'd0, it.in_port);
			end
		end else if (it.cmd == CMD_STATUS) begin
			if (it.in_port < PORT_COUNT)
				nb_go[it.in_port] = it.neighbour_go;
		end else if (it.cmd == CMD_LOCAL) begin
			local_rdy = it.local_ack;
		end
		// scan ports east to local
		for (int p = 0; p < PORT_COUNT; p++) begin
			if (bound_to[p] == ROUTE_NONE && fill_level(p) != 0) begin
				to = xy_target(buf_flits[p][rd_ptr[p]]);
				taken = 0;
				for (int q = 0; q < PORT_COUNT; q++)
					if (bound_to[q] == to) taken = 1;
				if (!taken) bound_to[p] = to;
			end
			if (bound_to[p] == PORT_LOCAL) begin
				if (fill_level(p) != 0 && local_rdy) begin
					forward_flit(p);
					local_rdy = 1'b0;
				end
			end else if (bound_to[p] < PORT_LOCAL) begin
				to = bound_to[p];
				while (bound_to[p] == to && nb_go[to] && fill_level(p) != 0)
					forward_flit(p);
			end
		end
		if (forwarded_q.size() > first)
			forwarded_q[forwarded_q.size() - 1].last = 1'b1;
	endfunction

	function automatic int pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (item_q.size() > 0) begin
				in_ch.data <= item_q.pop_front();
				in_ch.valid <= 1'b1;
				send_gap <= pick_delay();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		result_t exp_r;
		result_t got;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
			quiet_cycles <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				route_item(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (forwarded_q.size() == 0) begin
					$error("result transfer with nothing expected: %0h", got);
					err_cnt++;
				end else begin
					exp_r = forwarded_q.pop_front();
					if (got.result_kind !== exp_r.result_kind) begin
						$error("result_kind exp %0h got %0h", exp_r.result_kind, got.result_kind);
						err_cnt++;
					end
					if (got.out_port !== exp_r.out_port) begin
						$error("out_port exp %0h got %0h", exp_r.out_port, got.out_port);
						err_cnt++;
					end
					if (got.flit_out !== exp_r.flit_out) begin
						$error("flit_out exp %0h got %0h", exp_r.flit_out, got.flit_out);
						err_cnt++;
					end
					if (got.status_port !== exp_r.status_port) begin
						$error("status_port exp %0h got %0h", exp_r.status_port,
							got.status_port);
						err_cnt++;
					end
					if (got.status_stall !== exp_r.status_stall) begin
						$error("status_stall exp %0h got %0h", exp_r.status_stall,
							got.status_stall);
						err_cnt++;
					end
					if (got.last !== exp_r.last) begin
						$error("last exp %0h got %0h", exp_r.last, got.last);
						err_cnt++;
					end
				end
			end
			// receiver stalls
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				recv_stall <= pick_delay();
			end
			// watchdog on cycles with work pending but no transfer
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (!in_ch.valid && in_ch.ready && item_q.size() == 0
					&& forwarded_q.size() == 0)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL wormhole_xy_mesh_router_top");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic item_t mk_item(logic [1:0] c, logic [2:0] p, logic [31:0] f,
			logic go, logic ack);
		item_t it;
		it.cmd = c;
		it.in_port = p;
		it.flit_in = f;
		it.neighbour_go = go;
		it.local_ack = ack;
		return it;
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (item_q.size() != 0 || in_ch.valid || forwarded_q.size() != 0 || !in_ch.ready);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_node(logic [3:0] x, logic [3:0] y);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NODE_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= CFG_NODE_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_we <= 1'b0;
		my_x = x;
		my_y = y;
	endtask

	// one well-formed packet from a random port, control items mixed in
	task automatic queue_packet(int max_len);
		logic [2:0] p;
		int n;
		p = 3'($urandom_range(0, PORT_COUNT - 1));
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 3);
		item_q.push_back(mk_item(CMD_FLIT, p, $urandom(), 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, p, {8'(n), 24'($urandom())}, 1'b0, 1'b0));
		for (int i = 0; i < n; i++) begin
			item_q.push_back(mk_item(CMD_FLIT, p, $urandom(), 1'b0, 1'b0));
			if ($urandom_range(0, 3) == 0)
				item_q.push_back(mk_item(CMD_LOCAL, 3'($urandom()), $urandom(),
					1'($urandom()), 1'b1));
		end
	endtask

	task automatic queue_random(int count);
		int start;
		int r;
		start = item_q.size();
		while (item_q.size() - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				queue_packet(6);
			end else if (r < 75) begin
				// neighbour status, mostly go
				item_q.push_back(mk_item(CMD_STATUS, 3'($urandom_range(0, 4)), $urandom(),
					$urandom_range(0, 3) != 0, 1'($urandom())));
			end else if (r < 88) begin
				item_q.push_back(mk_item(CMD_LOCAL, 3'($urandom()), $urandom(),
					1'($urandom()), $urandom_range(0, 3) != 0));
			end else if (r < 94) begin
				item_q.push_back(mk_item(CMD_POLL, 3'($urandom()), $urandom(),
					1'($urandom()), 1'($urandom())));
			end else begin
				// loose flit or write to a port that does not exist
				item_q.push_back(mk_item(2'($urandom_range(0, 1)), 3'($urandom()), $urandom(),
					1'($urandom()), 1'($urandom())));
			end
		end
	endtask

	// stimulus sequence
	initial begin
		err_cnt = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: node at reset coordinates 15,15
		item_q.push_back(mk_item(CMD_POLL, PORT_EAST, 32'h0, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_STATUS, 3'd7, 32'hFFFFFFFF, 1'b0, 1'b1));
		item_q.push_back(mk_item(CMD_FLIT, 3'd5, 32'hFFFFFFFF, 1'b1, 1'b1));
		// packet to local, paced by acknowledgments
		item_q.push_back(mk_item(CMD_FLIT, PORT_EAST, 32'hFF000000, 1'b1, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_EAST, 32'h02FFFFFF, 1'b1, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_EAST, 32'hFFFFFFFF, 1'b1, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_EAST, 32'h00000001, 1'b1, 1'b0));
		for (int i = 0; i < 4; i++)
			item_q.push_back(mk_item(CMD_LOCAL, PORT_LOCAL, 32'h0, 1'b0, 1'b1));
		item_q.push_back(mk_item(CMD_LOCAL, PORT_LOCAL, 32'h0, 1'b1, 1'b0));
		// west stalled: fill the south buffer past full, then release
		item_q.push_back(mk_item(CMD_STATUS, PORT_WEST, 32'h0, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_STATUS, PORT_LOCAL, 32'h0, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_SOUTH, 32'h00000000, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_SOUTH, 32'h05000000, 1'b0, 1'b0));
		for (int i = 0; i < 7; i++)
			item_q.push_back(mk_item(CMD_FLIT, PORT_SOUTH, 32'hA5A5A5A5 ^ i, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_STATUS, PORT_WEST, 32'h0, 1'b1, 1'b0));
		// size flit of zero frees the route at once
		item_q.push_back(mk_item(CMD_FLIT, PORT_NORTH, 32'h0F000000, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_FLIT, PORT_NORTH, 32'h00123456, 1'b0, 1'b0));
		item_q.push_back(mk_item(CMD_STATUS, PORT_LOCAL, 32'h0, 1'b1, 1'b0));
		wait_idle();

		// node at the origin, no idling
		set_node(4'h0, 4'h0);
		no_gaps = 1;
		queue_random(23);
		wait_idle();

		// extremes in opposite corners and a random node
		no_gaps = 0;
		set_node(4'hF, 4'h0);
		queue_random(23);
		wait_idle();
		set_node(4'h0, 4'hF);
		queue_random(23);
		wait_idle();
		set_node(4'($urandom()), 4'($urandom()));
		queue_random(23);
		wait_idle();

		if (err_cnt == 0)
			$display("PASS wormhole_xy_mesh_router_top");
		else
			$display("FAIL wormhole_xy_mesh_router_top");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
design/wxmr_pkg.sv
design/wxmr_if.sv
design/wxmr_ram.sv
design/wormhole_xy_mesh_router_top.sv
design/wxmr_checker.sv
sim/wormhole_xy_mesh_router_top_tb.sv
